### hdl/hsv_to_rgb_converter_macros.svh
// Assertion macros for the colour converter.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define HSV_ASSERT_NOW(lbl, clk_i, rstn_i, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond) |-> (cons)) \
    else $error("hsv_to_rgb_converter: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define HSV_ASSERT_NEXT(lbl, clk_i, rstn_i, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond) |=> (cons)) \
    else $error("hsv_to_rgb_converter: next-cycle check failed");

`endif

### hdl/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

  // Width of one colour channel.
  localparam int CHAN_W = 8;

  // Width of the hue sector number.
  localparam int SECTOR_W = 3;

  // Hue sectors, one sixth of a turn each.
  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

`default_nettype wire

### hdl/hsv_to_rgb_converter.sv
// Four register stages: an input transfer moves through stage 1, stage 2, stage 3 and the output
// register; with out_ready high, one pixel per clock flows through. A stage holds its pixel
// only while the next cannot load, so a low out_ready stalls the stages behind it.
// Stages: clamp and hue split; V(1-S), S*f, S*(1-f); V(1-S*f), V(1-S(1-f)); routing, scaling.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [FRAC_BITS-1:0]        in_hue,
  input  wire logic [FRAC_BITS:0]          in_saturation,
  input  wire logic [FRAC_BITS:0]          in_brightness,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hsv_pkg::CHAN_W-1:0]       out_red,
  output logic [hsv_pkg::CHAN_W-1:0]       out_green,
  output logic [hsv_pkg::CHAN_W-1:0]       out_blue
);

  import hsv_pkg::*;

  `include "hsv_to_rgb_converter_macros.svh"

  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Stage handshake: a stage may load when it is empty or its content moves on.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !s3_valid_r || rdy3;
  assign rdy1     = !s2_valid_r || rdy2;
  assign in_ready = !s1_valid_r || rdy1;

  // Stage 1: clamp inputs, split hue into sector and fraction.
  logic [F:0]   sat_c, val_c;
  logic [F+2:0] h6;
  logic [F:0]   s1_sat_r, s1_val_r, s1_sat_nxt, s1_val_nxt;
  logic [F-1:0] s1_frac_r, s1_frac_nxt;
  sector_t      s1_sector_r, s1_sector_nxt;

  always_comb begin
    sat_c         = (in_saturation > ONE) ? ONE : in_saturation;
    val_c         = (in_brightness > ONE) ? ONE : in_brightness;
    h6            = (F+3)'(in_hue) * (F+3)'(6);
    s1_sat_nxt    = sat_c;
    s1_val_nxt    = val_c;
    s1_frac_nxt   = h6[F-1:0];
    s1_sector_nxt = sector_t'(h6[F+2:F]);
  end

  // Stage 2: p = V(1-S), and the saturation products S*f and S*(1-f).
  logic [PW-1:0] prod_p, prod_sf, prod_sg;
  logic [F:0]    s2_val_r, s2_p_r, s2_sf_r, s2_sg_r;
  logic [F:0]    s2_val_nxt, s2_p_nxt, s2_sf_nxt, s2_sg_nxt;
  sector_t       s2_sector_r, s2_sector_nxt;

  always_comb begin
    prod_p        = PW'(s1_val_r) * PW'(ONE - s1_sat_r);
    prod_sf       = PW'(s1_sat_r) * PW'({1'b0, s1_frac_r});
    prod_sg       = PW'(s1_sat_r) * PW'(ONE - {1'b0, s1_frac_r});
    s2_val_nxt    = s1_val_r;
    s2_p_nxt      = prod_p[2*F:F];
    s2_sf_nxt     = prod_sf[2*F:F];
    s2_sg_nxt     = prod_sg[2*F:F];
    s2_sector_nxt = s1_sector_r;
  end

  // Stage 3: q = V(1-S*f) and t = V(1-S*(1-f)).
  logic [PW-1:0] prod_q, prod_t;
  logic [F:0]    s3_val_r, s3_p_r, s3_q_r, s3_t_r;
  logic [F:0]    s3_val_nxt, s3_p_nxt, s3_q_nxt, s3_t_nxt;
  sector_t       s3_sector_r, s3_sector_nxt;

  always_comb begin
    prod_q        = PW'(s2_val_r) * PW'(ONE - s2_sf_r);
    prod_t        = PW'(s2_val_r) * PW'(ONE - s2_sg_r);
    s3_val_nxt    = s2_val_r;
    s3_p_nxt      = s2_p_r;
    s3_q_nxt      = prod_q[2*F:F];
    s3_t_nxt      = prod_t[2*F:F];
    s3_sector_nxt = s2_sector_r;
  end

  // Stage 4: route the terms by sector and scale each channel by 255.
  logic [F:0]   r_frac, g_frac, b_frac;
  logic [F+8:0] r_255, g_255, b_255;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;

  always_comb begin
    unique case (s3_sector_r)
      SEC_RED_YELLOW: begin
        r_frac = s3_val_r; g_frac = s3_t_r;   b_frac = s3_p_r;
      end
      SEC_YELLOW_GREEN: begin
        r_frac = s3_q_r;   g_frac = s3_val_r; b_frac = s3_p_r;
      end
      SEC_GREEN_CYAN: begin
        r_frac = s3_p_r;   g_frac = s3_val_r; b_frac = s3_t_r;
      end
      SEC_CYAN_BLUE: begin
        r_frac = s3_p_r;   g_frac = s3_q_r;   b_frac = s3_val_r;
      end
      SEC_BLUE_MAGENTA: begin
        r_frac = s3_t_r;   g_frac = s3_p_r;   b_frac = s3_val_r;
      end
      default: begin
        r_frac = s3_val_r; g_frac = s3_p_r;   b_frac = s3_q_r;
      end
    endcase
    // Times 255 is times 256 minus one copy.
    r_255     = {r_frac, 8'b0} - (F+9)'(r_frac);
    g_255     = {g_frac, 8'b0} - (F+9)'(g_frac);
    b_255     = {b_frac, 8'b0} - (F+9)'(b_frac);
    red_nxt   = r_255[F+7:F];
    green_nxt = g_255[F+7:F];
    blue_nxt  = b_255[F+7:F];
  end

  // Valid bits follow the stage handshake.
  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    s2_valid_nxt  = rdy1 ? s1_valid_r : s2_valid_r;
    s3_valid_nxt  = rdy2 ? s2_valid_r : s3_valid_r;
    out_valid_nxt = rdy3 ? s3_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load whenever their stage may accept.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_sat_r    <= s1_sat_nxt;
      s1_val_r    <= s1_val_nxt;
      s1_frac_r   <= s1_frac_nxt;
      s1_sector_r <= s1_sector_nxt;
    end
    if (rdy1) begin
      s2_val_r    <= s2_val_nxt;
      s2_p_r      <= s2_p_nxt;
      s2_sf_r     <= s2_sf_nxt;
      s2_sg_r     <= s2_sg_nxt;
      s2_sector_r <= s2_sector_nxt;
    end
    if (rdy2) begin
      s3_val_r    <= s3_val_nxt;
      s3_p_r      <= s3_p_nxt;
      s3_q_r      <= s3_q_nxt;
      s3_t_r      <= s3_t_nxt;
      s3_sector_r <= s3_sector_nxt;
    end
    if (rdy3) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // A hue below one turn never produces a sector beyond magenta-red.
  `HSV_ASSERT_NOW(a_sector_range, clk, rst_n, s1_valid_r, s1_sector_r <= SEC_MAGENTA_RED)
  // The p term never exceeds the value.
  `HSV_ASSERT_NOW(a_p_bounded, clk, rst_n, s2_valid_r, s2_p_r <= s2_val_r)
  // The q and t terms never exceed the value.
  `HSV_ASSERT_NOW(a_qt_bounded, clk, rst_n, s3_valid_r,
                  (s3_q_r <= s3_val_r) && (s3_t_r <= s3_val_r))
  // A pixel leaving the last working stage is presented at the output next cycle.
  `HSV_ASSERT_NEXT(a_s3_to_out, clk, rst_n, s3_valid_r && rdy3, out_valid_r)

endmodule

`default_nettype wire
